/* rtl/core/rvrp_pkg.sv */
// Shared types and constants for the replay varint record parser.
// Depends on nothing; used by every module under rtl/core.
package rvrp_pkg;

   localparam int MaxVarintBytes = 10;

   // Result queue geometry; the depth is a power of two so the pointers wrap.
   localparam int QueueDepth   = 4;
   localparam int QueueIdxBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_DEATH  = 3'd1,
      KIND_INPUT  = 3'd2,
      KIND_DONE   = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MAGIC     = 3'd1,
      ERR_TRUNC     = 3'd2,
      ERR_VARINT    = 3'd3,
      ERR_STRING    = 3'd4,
      ERR_COUNT     = 3'd5,
      ERR_OVERFLOW  = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      FT_VAR  = 3'd0,
      FT_STR  = 3'd1,
      FT_FLT  = 3'd2,
      FT_DBL  = 3'd3,
      FT_BOOL = 3'd4,
      FT_EXT  = 3'd5
   } field_kind_type;

   // One result beat as it travels through the queue.
   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  field_index;
      logic [63:0] value;
      logic [1:0]  button;
      logic        second_player;
      logic        pressed;
      logic [2:0]  err_code;
      logic        last_result;
   } result_type;

   localparam int ResultBits = $bits(result_type);

   function automatic field_kind_type field_kind(input logic [4:0] f);
      field_kind_type k;
      unique case (f)
         5'd1, 5'd2, 5'd3, 5'd11, 5'd14: k = FT_STR;
         5'd4:                           k = FT_FLT;
         5'd6:                           k = FT_DBL;
         5'd9, 5'd10:                    k = FT_BOOL;
         5'd15:                          k = FT_EXT;
         default:                        k = FT_VAR;
      endcase
      return k;
   endfunction

endpackage

/* rtl/core/replay_varint_record_parser.sv */
// Top level of the replay varint record parser: front parse stage and result queue.
// Depends on rvrp_pkg, rvrp_front and rvrp_queue.
// Beats are registered in the queue and drained one per cycle while rsp_ready is high.
// Throughput: one byte per cycle while not stalled; a byte yields up to two beats.
// The four-entry result queue stalls the input while more than two beats wait in it.
// Reset is synchronous, active high, and starts a fresh file with an empty queue.
module replay_varint_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [4:0]  rsp_field_index,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_button,
   output logic        rsp_second_player,
   output logic        rsp_pressed,
   output logic [2:0]  rsp_err_code,
   output logic        rsp_last_result
);

   rvrp_pkg::result_type res0, res1, head;
   logic [1:0] res_count;
   logic       has_room;

   assign req_ready = has_room;

   rvrp_front u_front (
      .clock, .reset,
      .byte_valid (req_valid && req_ready),
      .data_byte  (req_data_byte),
      .end_of_file(req_end_of_file),
      .res0, .res1, .res_count
   );

   rvrp_queue u_queue (
      .clock, .reset,
      .push0 (res0), .push1 (res1), .push_count(res_count),
      .has_room, .head, .head_valid(rsp_valid), .pop(rsp_ready)
   );

   assign rsp_kind          = head.kind;
   assign rsp_field_index   = head.field_index;
   assign rsp_value         = head.value;
   assign rsp_button        = head.button;
   assign rsp_second_player = head.second_player;
   assign rsp_pressed       = head.pressed;
   assign rsp_err_code      = head.err_code;
   assign rsp_last_result   = head.last_result;

   // Only error beats carry an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_err_code != rvrp_pkg::ERR_NONE |-> rsp_kind == rvrp_pkg::KIND_ERROR)
      else $error("error code on a non-error beat");

   // A stalled input never pushes results into the queue.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> res_count == 2'd0)
      else $error("results pushed while input stalled");

   // When one byte yields two beats, only the second carries the last marker.
   assert property (@(posedge clock) disable iff (reset)
      res_count == 2'd2 |-> res1.last_result && !res0.last_result)
      else $error("last marker misplaced");

endmodule

/* rtl/core/rvrp_front.sv */
// Front part: takes one byte per beat, runs the file parse state and
// produces up to two result beats per byte. Depends on rvrp_pkg.
module rvrp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_file,
   output rvrp_pkg::result_type  res0,
   output rvrp_pkg::result_type  res1,
   output logic [1:0]            res_count
);

   typedef enum logic [2:0] {
      PH_MAGIC, PH_HDR, PH_HSKIP, PH_DEATHS, PH_INPUT, PH_IEXT, PH_ISKIP, PH_DRAIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hfield_ff, hfield_in;
   logic [63:0] vacc_ff, vacc_in;
   logic [3:0]  vbytes_ff, vbytes_in;
   logic [63:0] skip_ff, skip_in;
   logic [63:0] raw_ff, raw_in;
   logic [3:0]  rawn_ff, rawn_in;
   logic        tag_ff, tag_in;
   logic        plat_ff, plat_in;
   logic [63:0] deaths_ff, deaths_in;
   logic [63:0] dbase_ff, dbase_in;
   logic [63:0] inleft_ff, inleft_in;
   logic [63:0] p1tot_ff, p1tot_in;
   logic [63:0] p1seen_ff, p1seen_in;
   logic [63:0] fbase_ff, fbase_in;

   // Varint step results.
   logic [63:0] vfull;
   logic        vdone, vlong;
   logic [6:0]  shamt;
   logic [63:0] rawsh;
   logic [64:0] dsum, fsum;
   logic [63:0] packed_v, delta;
   logic [1:0]  btn;
   rvrp_pkg::field_kind_type fk;
   logic [63:0] fv;

   always_comb begin
      shamt = 7'(vbytes_ff) * 7'd7;
      vfull = vacc_ff;
      if (shamt < 7'd64) begin
         vfull = vacc_ff | ({57'd0, data_byte[6:0]} << shamt[5:0]);
      end
      vdone = !data_byte[7];
      vlong = data_byte[7] && (vbytes_ff + 4'd1 >= 4'(rvrp_pkg::MaxVarintBytes));
      rawsh = {raw_ff[55:0], data_byte};
      dsum  = {1'b0, vfull} + {1'b0, dbase_ff};
      packed_v = vfull;
      if (plat_ff) begin
         btn = packed_v[2:1];
         delta = {3'd0, packed_v[63:3]};
      end else begin
         btn = 2'd1;
         delta = {1'b0, packed_v[63:1]};
      end
      fsum = {1'b0, delta} + {1'b0, fbase_ff};
      fk = rvrp_pkg::field_kind(hfield_ff);
      fv = (fk == rvrp_pkg::FT_FLT) ? {32'd0, rawsh[31:0]} : rawsh;
      if (fk != rvrp_pkg::FT_FLT && fk != rvrp_pkg::FT_DBL) fv = vfull;
   end

   // Main parse step; results are gathered into two slots.
   always_comb begin
      rvrp_pkg::result_type r [2];
      logic [1:0] n;
      logic hdone, finish_now;
      logic [63:0] hv;
      logic p2;

      phase_in = phase_ff; hfield_in = hfield_ff; vacc_in = vacc_ff;
      vbytes_in = vbytes_ff; skip_in = skip_ff; raw_in = raw_ff; rawn_in = rawn_ff;
      tag_in = tag_ff; plat_in = plat_ff; deaths_in = deaths_ff; dbase_in = dbase_ff;
      inleft_in = inleft_ff; p1tot_in = p1tot_ff; p1seen_in = p1seen_ff;
      fbase_in = fbase_ff;
      r[0] = '0; r[1] = '0; n = 2'd0;
      hdone = 1'b0; finish_now = 1'b0; hv = fv;
      p2 = p1seen_ff >= p1tot_ff;

      unique case (phase_ff)
         PH_MAGIC: begin
            raw_in = rawsh; rawn_in = rawn_ff + 4'd1;
            if (rawn_ff >= 4'd2) begin
               raw_in = '0; rawn_in = '0;
               if (rawsh[23:0] == 24'h474452) phase_in = PH_HDR;
               else begin
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_MAGIC;
                  n = 2'd1; phase_in = PH_DRAIN;
               end
            end
         end
         PH_HDR: begin
            if (fk == rvrp_pkg::FT_FLT || fk == rvrp_pkg::FT_DBL) begin
               raw_in = rawsh; rawn_in = rawn_ff + 4'd1;
               if (rawn_ff + 4'd1 >= ((fk == rvrp_pkg::FT_FLT) ? 4'd4 : 4'd8)) begin
                  raw_in = '0; rawn_in = '0; hdone = 1'b1;
               end
            end else begin
               vacc_in = vfull; vbytes_in = vbytes_ff + 4'd1;
               if (vdone) begin
                  vacc_in = '0; vbytes_in = '0; hdone = 1'b1;
               end else if (vlong) begin
                  vacc_in = '0; vbytes_in = '0;
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_VARINT;
                  n = 2'd1; phase_in = PH_DRAIN;
               end
            end
            if (hdone) begin
               if (fk == rvrp_pkg::FT_STR && hv > 64'hFFFF) begin
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_STRING;
                  n = 2'd1; phase_in = PH_DRAIN;
               end else if (hfield_ff == 5'd18 && hv > inleft_ff) begin
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_COUNT;
                  n = 2'd1; phase_in = PH_DRAIN;
               end else begin
                  if (fk == rvrp_pkg::FT_STR) begin
                     skip_in = hv;
                     if (hfield_ff == 5'd1) tag_in = hv != '0;
                  end else if (fk == rvrp_pkg::FT_EXT) begin
                     skip_in = hv;
                  end else if (fk == rvrp_pkg::FT_BOOL) begin
                     hv = {63'd0, fv != '0};
                     if (hfield_ff == 5'd10) plat_in = fv != '0;
                  end
                  if (hfield_ff == 5'd16) begin deaths_in = hv; dbase_in = '0; end
                  if (hfield_ff == 5'd17) inleft_in = hv;
                  if (hfield_ff == 5'd18) begin
                     p1tot_in = hv; p1seen_in = '0; fbase_in = '0;
                  end
                  r[0].kind = rvrp_pkg::KIND_HEADER; r[0].field_index = hfield_ff;
                  r[0].value = hv; n = 2'd1;
                  hfield_in = hfield_ff + 5'd1;
                  if (skip_in != '0) phase_in = PH_HSKIP;
                  else if (hfield_ff == 5'd16 && hv != '0) phase_in = PH_DEATHS;
                  else if (hfield_ff == 5'd18) begin
                     if (inleft_ff != '0) phase_in = PH_INPUT;
                     else finish_now = 1'b1;
                  end else phase_in = PH_HDR;
               end
            end
         end
         PH_HSKIP: begin
            if (skip_ff != '0) skip_in = skip_ff - 64'd1;
            if (skip_ff <= 64'd1) phase_in = PH_HDR;
         end
         PH_DEATHS: begin
            vacc_in = vfull; vbytes_in = vbytes_ff + 4'd1;
            if (vdone) begin
               vacc_in = '0; vbytes_in = '0;
               if (dsum[64]) begin
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_OVERFLOW;
                  n = 2'd1; phase_in = PH_DRAIN;
               end else begin
                  dbase_in = dsum[63:0];
                  r[0].kind = rvrp_pkg::KIND_DEATH; r[0].value = dsum[63:0]; n = 2'd1;
                  if (deaths_ff != '0) deaths_in = deaths_ff - 64'd1;
                  if (deaths_ff <= 64'd1) phase_in = PH_HDR;
               end
            end else if (vlong) begin
               vacc_in = '0; vbytes_in = '0;
               r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_VARINT;
               n = 2'd1; phase_in = PH_DRAIN;
            end
         end
         PH_INPUT: begin
            vacc_in = vfull; vbytes_in = vbytes_ff + 4'd1;
            if (vdone) begin
               vacc_in = '0; vbytes_in = '0;
               if (fsum[64]) begin
                  r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_OVERFLOW;
                  n = 2'd1; phase_in = PH_DRAIN;
               end else begin
                  r[0].kind = rvrp_pkg::KIND_INPUT; r[0].value = fsum[63:0];
                  r[0].button = btn; r[0].second_player = p2;
                  r[0].pressed = packed_v[0]; n = 2'd1;
                  fbase_in = fsum[63:0];
                  if (!p2) begin
                     p1seen_in = p1seen_ff + 64'd1;
                     if (p1seen_ff + 64'd1 == p1tot_ff) fbase_in = '0;
                  end
                  if (tag_ff) phase_in = PH_IEXT;
                  else begin
                     inleft_in = inleft_ff - 64'd1;
                     if (inleft_ff == 64'd1) finish_now = 1'b1;
                     else phase_in = PH_INPUT;
                  end
               end
            end else if (vlong) begin
               vacc_in = '0; vbytes_in = '0;
               r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_VARINT;
               n = 2'd1; phase_in = PH_DRAIN;
            end
         end
         PH_IEXT: begin
            vacc_in = vfull; vbytes_in = vbytes_ff + 4'd1;
            if (vdone) begin
               vacc_in = '0; vbytes_in = '0; skip_in = vfull;
               if (vfull != '0) phase_in = PH_ISKIP;
               else begin
                  inleft_in = inleft_ff - 64'd1;
                  if (inleft_ff == 64'd1) finish_now = 1'b1;
                  else phase_in = PH_INPUT;
               end
            end else if (vlong) begin
               vacc_in = '0; vbytes_in = '0;
               r[0].kind = rvrp_pkg::KIND_ERROR; r[0].err_code = rvrp_pkg::ERR_VARINT;
               n = 2'd1; phase_in = PH_DRAIN;
            end
         end
         PH_ISKIP: begin
            if (skip_ff != '0) skip_in = skip_ff - 64'd1;
            if (skip_ff <= 64'd1) begin
               inleft_in = inleft_ff - 64'd1;
               if (inleft_ff == 64'd1) finish_now = 1'b1;
               else phase_in = PH_INPUT;
            end
         end
         default: ;
      endcase

      // Finish appends a done beat after whatever this byte produced.
      if (finish_now) begin
         r[n[0]] = '0; r[n[0]].kind = rvrp_pkg::KIND_DONE;
         n = n + 2'd1; phase_in = PH_DRAIN;
      end

      // End of file closes the parse and starts a new file.
      if (end_of_file) begin
         if (phase_in != PH_DRAIN) begin
            r[n[0]] = '0;
            if (phase_in == PH_INPUT && vbytes_in == '0) r[n[0]].kind = rvrp_pkg::KIND_DONE;
            else begin
               r[n[0]].kind = rvrp_pkg::KIND_ERROR; r[n[0]].err_code = rvrp_pkg::ERR_TRUNC;
            end
            n = n + 2'd1;
         end
         phase_in = PH_MAGIC; hfield_in = '0; vacc_in = '0; vbytes_in = '0;
         skip_in = '0; raw_in = '0; rawn_in = '0; tag_in = 1'b0; plat_in = 1'b0;
         deaths_in = '0; dbase_in = '0; inleft_in = '0; p1tot_in = '0;
         p1seen_in = '0; fbase_in = '0;
      end

      if (n == 2'd1) r[0].last_result = 1'b1;
      if (n == 2'd2) r[1].last_result = 1'b1;
      res0 = r[0]; res1 = r[1];
      res_count = byte_valid ? n : 2'd0;
   end

   // Parse state registers advance on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; hfield_ff <= '0; vacc_ff <= '0; vbytes_ff <= '0;
         skip_ff <= '0; raw_ff <= '0; rawn_ff <= '0; tag_ff <= 1'b0; plat_ff <= 1'b0;
         deaths_ff <= '0; dbase_ff <= '0; inleft_ff <= '0; p1tot_ff <= '0;
         p1seen_ff <= '0; fbase_ff <= '0;
      end else if (byte_valid) begin
         phase_ff <= phase_in; hfield_ff <= hfield_in; vacc_ff <= vacc_in;
         vbytes_ff <= vbytes_in; skip_ff <= skip_in; raw_ff <= raw_in;
         rawn_ff <= rawn_in; tag_ff <= tag_in; plat_ff <= plat_in;
         deaths_ff <= deaths_in; dbase_ff <= dbase_in; inleft_ff <= inleft_in;
         p1tot_ff <= p1tot_in; p1seen_ff <= p1seen_in; fbase_ff <= fbase_in;
      end
   end

endmodule

/* rtl/core/rvrp_queue.sv */
// Back part: a small result queue that takes up to two beats per cycle and
// hands out one beat per cycle while pop is high. Depends on rvrp_pkg.
module rvrp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  rvrp_pkg::result_type  push0,
   input  rvrp_pkg::result_type  push1,
   input  logic [1:0]            push_count,
   output logic                  has_room,
   output rvrp_pkg::result_type  head,
   output logic                  head_valid,
   input  logic                  pop
);

   rvrp_pkg::result_type slot_ff [rvrp_pkg::QueueDepth];
   logic [rvrp_pkg::QueueIdxBits-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [rvrp_pkg::QueueCntBits-1:0] cnt_ff, cnt_in;
   logic                              take;

   // Room for two beats keeps the front free to take any byte.
   assign has_room   = cnt_ff <= rvrp_pkg::QueueCntBits'(rvrp_pkg::QueueDepth - 2);
   assign head_valid = cnt_ff != '0;
   assign head       = slot_ff[rd_ff];
   assign take       = pop && head_valid;

   always_comb begin
      rd_in  = rd_ff + (take ? rvrp_pkg::QueueIdxBits'(1) : '0);
      wr_in  = wr_ff + rvrp_pkg::QueueIdxBits'(push_count);
      cnt_in = cnt_ff + rvrp_pkg::QueueCntBits'(push_count)
               - (take ? rvrp_pkg::QueueCntBits'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (push_count != '0) slot_ff[wr_ff] <= push0;
      if (push_count == 2'd2) slot_ff[wr_ff + rvrp_pkg::QueueIdxBits'(1)] <= push1;
   end

endmodule
